// File: sv/dd_pkg.sv
// ----------------------------------------------------------------------------
// dd_pkg: shared types and constants for the detection decode / NMS block
// Payload structs, register indexes and the controller-datapath link.
// ----------------------------------------------------------------------------
package dd_pkg;

  localparam int MaxDets    = 64;
  localparam int IdxW       = $clog2(MaxDets);
  localparam int CntW       = $clog2(MaxDets + 1);
  localparam int CoordW     = 13;
  localparam int ScoreW     = 16;
  localparam int FracShift  = 17;
  localparam int CornerW    = 19;
  localparam int ProdW      = 36;
  localparam int ClampW     = CoordW + FracShift;
  localparam int NumCorners = 4;
  localparam int BoxW       = 4 * CoordW;
  localparam int ClassW     = 2;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  // confidence_threshold reset is Q0.16 0.25, overlap 0.45, pad_y 70 px
  localparam logic [15:0] ConfThrRst = 16'd16384;
  localparam logic [15:0] OvlThrRst  = 16'd29491;
  localparam logic [15:0] PadXRst    = 16'd0;
  localparam logic [15:0] PadYRst    = 16'd1120;
  localparam logic [15:0] InvScRst   = 16'd12288;
  localparam logic [12:0] ImgWRst    = 13'd1920;
  localparam logic [12:0] ImgHRst    = 13'd1080;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CONF_THR  = 3'd0,
    CFG_OVL_THR   = 3'd1,
    CFG_PAD_X     = 3'd2,
    CFG_PAD_Y     = 3'd3,
    CFG_INV_SCALE = 3'd4,
    CFG_IMG_W     = 3'd5,
    CFG_IMG_H     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] box_w;
    logic [15:0] box_h;
    logic [15:0] score_a;
    logic [15:0] score_b;
    logic [15:0] score_c;
    logic        frame_end;
  } dd_in_t;

  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] height;
    logic [ClassW-1:0] label;
    logic [ScoreW-1:0] confidence;
    logic              last_box;
    logic              no_box;
    logic              overflow;
  } dd_out_t;

  typedef struct packed {
    logic accept;
    logic dec_step;
    logic store;
    logic clr_i;
    logic i_inc;
    logic sc_rd_i;
    logic sc_rd_j;
    logic sc_rd_ord;
    logic ord_rd_i;
    logic ord_rd_j;
    logic box_rd;
    logic srt_ldi;
    logic srt_cmp;
    logic srt_wr;
    logic nms_lda;
    logic nms_s1;
    logic nms_s2;
    logic nms_s3;
    logic nms_s4;
    logic nms_s5;
    logic out_load;
    logic nobox_load;
    logic finish;
  } dd_cmd_t;

  typedef struct packed {
    logic store_ok;
    logic in_frame_end;
    logic frame_end;
    logic dec_last;
    logic i_end;
    logic j_end;
    logic j_last;
    logic keep_i;
    logic emitted;
    logic out_free;
  } dd_sts_t;

endpackage

// File: sv/detection_decode_nms.sv
// ----------------------------------------------------------------------------
// detection_decode_nms: anchor decode with greedy non-maximum suppression
// Top level: sequencer plus datapath.
// ----------------------------------------------------------------------------
// Anchors arrive on in_valid_i/in_ready_o, one request per anchor, results
// leave on out_valid_o/out_ready_i from an output register. Configuration is
// written on cfg_valid_i with cfg_idx_i/cfg_data_i; cfg_ready_o stays high.
// An anchor below the confidence threshold, or one past full storage, is
// only accepted; a stored anchor goes through accept, four corner multiplies
// through the single scale multiplier plus a clamp step, and a store step.
// On the anchor that ends a frame, input stalls while the frame is processed:
// the rank sort reads the score memory once per pair of boxes plus once per
// box for its own score; NMS tests each kept box against every box ranked
// behind it (one memory port, one IoU pipeline); emission walks the kept
// boxes in rank order, then closes the frame with a no-box result if none
// was kept. A stalled receiver holds the sequencer at the output register;
// nothing is dropped. Reset restores register defaults and empties the box
// storage (stores are only read below the box count, no clearing pass).
// ----------------------------------------------------------------------------
module detection_decode_nms (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dd_pkg::dd_in_t              in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dd_pkg::dd_out_t             out_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dd_pkg::CfgDataW-1:0] cfg_data_i
);
  import dd_pkg::*;

  dd_cmd_t cmd;
  dd_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// File: sv/dd_ctrl.sv
// ----------------------------------------------------------------------------
// dd_ctrl: frame sequencer
// Steps the datapath through decode, rank sort, NMS and result emission.
// ----------------------------------------------------------------------------
module dd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dd_pkg::dd_sts_t sts_i,
  output dd_pkg::dd_cmd_t cmd_o
);
  import dd_pkg::*;

  typedef enum logic [22:0] {
    ST_IDLE  = 23'd1 << 0,
    ST_DEC   = 23'd1 << 1,
    ST_STORE = 23'd1 << 2,
    ST_SRI   = 23'd1 << 3,
    ST_SLI   = 23'd1 << 4,
    ST_SRJ   = 23'd1 << 5,
    ST_SCJ   = 23'd1 << 6,
    ST_SWR   = 23'd1 << 7,
    ST_NI    = 23'd1 << 8,
    ST_NIA   = 23'd1 << 9,
    ST_NIB   = 23'd1 << 10,
    ST_NJ    = 23'd1 << 11,
    ST_NJA   = 23'd1 << 12,
    ST_NJB   = 23'd1 << 13,
    ST_NJC   = 23'd1 << 14,
    ST_NJD   = 23'd1 << 15,
    ST_NJE   = 23'd1 << 16,
    ST_NJF   = 23'd1 << 17,
    ST_OI    = 23'd1 << 18,
    ST_OA    = 23'd1 << 19,
    ST_OB    = 23'd1 << 20,
    ST_ONB   = 23'd1 << 21,
    ST_FIN   = 23'd1 << 22
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.store_ok) begin
            state_d = ST_DEC;
          end else if (sts_i.in_frame_end) begin
            cmd_o.clr_i = 1'b1;
            state_d     = ST_SRI;
          end
        end
      end
      ST_DEC: begin
        cmd_o.dec_step = 1'b1;
        if (sts_i.dec_last) state_d = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        if (sts_i.frame_end) begin
          cmd_o.clr_i = 1'b1;
          state_d     = ST_SRI;
        end else begin
          state_d = ST_IDLE;
        end
      end
      // rank sort: position of box i is the count of boxes ahead of it
      ST_SRI: begin
        if (sts_i.i_end) begin
          cmd_o.clr_i = 1'b1;
          state_d     = ST_NI;
        end else begin
          cmd_o.sc_rd_i = 1'b1;
          state_d       = ST_SLI;
        end
      end
      ST_SLI: begin
        cmd_o.srt_ldi = 1'b1;
        state_d       = ST_SRJ;
      end
      ST_SRJ: begin
        cmd_o.sc_rd_j = 1'b1;
        state_d       = ST_SCJ;
      end
      ST_SCJ: begin
        cmd_o.srt_cmp = 1'b1;
        state_d       = sts_i.j_last ? ST_SWR : ST_SRJ;
      end
      ST_SWR: begin
        cmd_o.srt_wr = 1'b1;
        state_d      = ST_SRI;
      end
      ST_NI: begin
        if (sts_i.i_end) begin
          cmd_o.clr_i = 1'b1;
          state_d     = ST_OI;
        end else if (!sts_i.keep_i) begin
          cmd_o.i_inc = 1'b1;
        end else begin
          cmd_o.ord_rd_i = 1'b1;
          state_d        = ST_NIA;
        end
      end
      ST_NIA: begin
        cmd_o.box_rd = 1'b1;
        state_d      = ST_NIB;
      end
      ST_NIB: begin
        cmd_o.nms_lda = 1'b1;
        state_d       = ST_NJ;
      end
      ST_NJ: begin
        if (sts_i.j_end) begin
          cmd_o.i_inc = 1'b1;
          state_d     = ST_NI;
        end else begin
          cmd_o.ord_rd_j = 1'b1;
          state_d        = ST_NJA;
        end
      end
      ST_NJA: begin
        cmd_o.box_rd = 1'b1;
        state_d      = ST_NJB;
      end
      ST_NJB: begin
        cmd_o.nms_s1 = 1'b1;
        state_d      = ST_NJC;
      end
      ST_NJC: begin
        cmd_o.nms_s2 = 1'b1;
        state_d      = ST_NJD;
      end
      ST_NJD: begin
        cmd_o.nms_s3 = 1'b1;
        state_d      = ST_NJE;
      end
      ST_NJE: begin
        cmd_o.nms_s4 = 1'b1;
        state_d      = ST_NJF;
      end
      ST_NJF: begin
        cmd_o.nms_s5 = 1'b1;
        state_d      = ST_NJ;
      end
      ST_OI: begin
        if (sts_i.i_end) begin
          state_d = sts_i.emitted ? ST_FIN : ST_ONB;
        end else if (!sts_i.keep_i) begin
          cmd_o.i_inc = 1'b1;
        end else begin
          cmd_o.ord_rd_i = 1'b1;
          state_d        = ST_OA;
        end
      end
      ST_OA: begin
        cmd_o.box_rd    = 1'b1;
        cmd_o.sc_rd_ord = 1'b1;
        state_d         = ST_OB;
      end
      ST_OB: begin
        // hold until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.i_inc    = 1'b1;
          state_d        = ST_OI;
        end
      end
      ST_ONB: begin
        if (sts_i.out_free) begin
          cmd_o.nobox_load = 1'b1;
          state_d          = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/dd_datapath.sv
// ----------------------------------------------------------------------------
// dd_datapath: decode, box storage, rank sort, IoU test and output register
// Driven step by step by dd_ctrl through the command struct.
// ----------------------------------------------------------------------------
module dd_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dd_pkg::dd_in_t             in_i,
  input  logic                       cfg_valid_i,
  input  logic [dd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dd_pkg::CfgDataW-1:0] cfg_data_i,
  input  dd_pkg::dd_cmd_t            cmd_i,
  output dd_pkg::dd_sts_t            sts_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output dd_pkg::dd_out_t            out_o
);
  import dd_pkg::*;

  // configuration
  logic [15:0] conf_thr_q, ovl_thr_q, pad_x_q, pad_y_q, inv_q;
  logic [CoordW-1:0] img_w_q, img_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_thr_q <= ConfThrRst;
      ovl_thr_q  <= OvlThrRst;
      pad_x_q    <= PadXRst;
      pad_y_q    <= PadYRst;
      inv_q      <= InvScRst;
      img_w_q    <= ImgWRst;
      img_h_q    <= ImgHRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CONF_THR:  conf_thr_q <= cfg_data_i;
        CFG_OVL_THR:   ovl_thr_q  <= cfg_data_i;
        CFG_PAD_X:     pad_x_q    <= cfg_data_i;
        CFG_PAD_Y:     pad_y_q    <= cfg_data_i;
        CFG_INV_SCALE: inv_q      <= cfg_data_i;
        CFG_IMG_W:     img_w_q    <= cfg_data_i[CoordW-1:0];
        CFG_IMG_H:     img_h_q    <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // class argmax, first maximum wins
  logic [ScoreW-1:0] conf_c;
  logic [ClassW-1:0] cls_c;
  always_comb begin
    conf_c = in_i.score_a;
    cls_c  = 2'd0;
    if (in_i.score_b > conf_c) begin
      conf_c = in_i.score_b;
      cls_c  = 2'd1;
    end
    if (in_i.score_c > conf_c) begin
      conf_c = in_i.score_c;
      cls_c  = 2'd2;
    end
  end

  logic conf_ok, full;
  logic [CntW-1:0] cnt_q;
  logic ovf_q, fe_q, emitted_q;
  logic [MaxDets-1:0] keep_q;
  logic [2:0] k_q;
  logic [CntW-1:0] i_q, j_q;
  logic [IdxW-1:0] rank_q;

  assign conf_ok = (conf_c >= conf_thr_q);
  assign full    = (cnt_q >= CntW'(MaxDets));

  // captured anchor
  dd_in_t in_q;
  logic [ClassW-1:0] cls_q;
  logic [ScoreW-1:0] conf_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_q   <= in_i;
      cls_q  <= cls_c;
      conf_q <= conf_c;
    end
  end

  // corner decode: one multiply per cycle, each product clamped in the next cycle
  logic [CornerW-1:0] two_c, size_v, two_p, corner_u;
  logic signed [ProdW-1:0] prod_d, p_q;
  logic [1:0] kidx;
  logic [CoordW-1:0] lim;
  logic [ClampW-1:0] hi, clamp_d;
  logic [ClampW-1:0] cr_q [NumCorners];

  always_comb begin
    if (k_q[0]) begin
      two_c  = {2'b0, in_q.center_y, 1'b0};
      size_v = {3'b0, in_q.box_h};
      two_p  = {2'b0, pad_y_q, 1'b0};
    end else begin
      two_c  = {2'b0, in_q.center_x, 1'b0};
      size_v = {3'b0, in_q.box_w};
      two_p  = {2'b0, pad_x_q, 1'b0};
    end
    corner_u = k_q[1] ? (two_c + size_v - two_p) : (two_c - size_v - two_p);
    prod_d   = $signed(corner_u) * $signed({1'b0, inv_q});
    kidx     = 2'(k_q - 3'd1);
    lim      = kidx[0] ? img_h_q : img_w_q;
    hi       = {lim, {FracShift{1'b0}}};
    if (p_q[ProdW-1]) begin
      clamp_d = '0;
    end else if (p_q > $signed({{(ProdW-ClampW){1'b0}}, hi})) begin
      clamp_d = hi;
    end else begin
      clamp_d = p_q[ClampW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dec_step) begin
      if (k_q < 3'(NumCorners)) p_q <= prod_d;
      if (k_q != 3'd0) cr_q[kidx] <= clamp_d;
    end
  end

  logic [ClampW-1:0] span_x, span_y;
  logic [BoxW-1:0] box_wr;
  assign span_x = cr_q[2] - cr_q[0];
  assign span_y = cr_q[3] - cr_q[1];
  assign box_wr = {span_y[ClampW-1:FracShift], span_x[ClampW-1:FracShift],
                   cr_q[1][ClampW-1:FracShift], cr_q[0][ClampW-1:FracShift]};

  // storage
  logic [BoxW-1:0] box_mem [MaxDets];
  logic [ClassW+ScoreW-1:0] sc_mem [MaxDets];
  logic [IdxW-1:0] ord_mem [MaxDets];
  logic [BoxW-1:0] box_rd_q;
  logic [ClassW+ScoreW-1:0] sc_rd_q;
  logic [IdxW-1:0] ord_rd_q;
  logic [IdxW-1:0] sc_addr, ord_addr;

  always_comb begin
    if (cmd_i.sc_rd_i) begin
      sc_addr = i_q[IdxW-1:0];
    end else if (cmd_i.sc_rd_j) begin
      sc_addr = j_q[IdxW-1:0];
    end else begin
      sc_addr = ord_rd_q;
    end
    ord_addr = cmd_i.ord_rd_i ? i_q[IdxW-1:0] : j_q[IdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) box_mem[cnt_q[IdxW-1:0]] <= box_wr;
    if (cmd_i.box_rd) box_rd_q <= box_mem[ord_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) sc_mem[cnt_q[IdxW-1:0]] <= {cls_q, conf_q};
    if (cmd_i.sc_rd_i || cmd_i.sc_rd_j || cmd_i.sc_rd_ord) sc_rd_q <= sc_mem[sc_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.srt_wr) ord_mem[rank_q] <= i_q[IdxW-1:0];
    if (cmd_i.ord_rd_i || cmd_i.ord_rd_j) ord_rd_q <= ord_mem[ord_addr];
  end

  // sort compare: box j ranks ahead of box i
  logic [ScoreW-1:0] si_q;
  logic ahead;
  assign ahead = (sc_rd_q[ScoreW-1:0] > si_q) ||
                 ((sc_rd_q[ScoreW-1:0] == si_q) && (j_q < i_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.srt_ldi) si_q <= sc_rd_q[ScoreW-1:0];
  end

  // IoU pipeline
  logic [BoxW-1:0] a_q;
  logic [CoordW-1:0] al, at, aw, ah, bl, bt, bw, bh, x1, y1;
  logic [CoordW:0] x2, y2, dx_d, dy_d, dx_q, dy_q;
  logic [CoordW-1:0] bw_q, bh_q;
  logic [2*CoordW+1:0] inter_q;
  logic [2*CoordW-1:0] aa_q, ab_q;
  logic [2*CoordW:0] uni_q;
  logic [2*CoordW+16:0] thrp_q;
  logic sup;

  always_comb begin
    al = a_q[0 +: CoordW];
    at = a_q[CoordW +: CoordW];
    aw = a_q[2*CoordW +: CoordW];
    ah = a_q[3*CoordW +: CoordW];
    bl = box_rd_q[0 +: CoordW];
    bt = box_rd_q[CoordW +: CoordW];
    bw = box_rd_q[2*CoordW +: CoordW];
    bh = box_rd_q[3*CoordW +: CoordW];
    x1 = (al > bl) ? al : bl;
    y1 = (at > bt) ? at : bt;
    x2 = ({1'b0, al} + {1'b0, aw} < {1'b0, bl} + {1'b0, bw}) ?
         ({1'b0, al} + {1'b0, aw}) : ({1'b0, bl} + {1'b0, bw});
    y2 = ({1'b0, at} + {1'b0, ah} < {1'b0, bt} + {1'b0, bh}) ?
         ({1'b0, at} + {1'b0, ah}) : ({1'b0, bt} + {1'b0, bh});
    dx_d = (x2 > {1'b0, x1}) ? (x2 - {1'b0, x1}) : '0;
    dy_d = (y2 > {1'b0, y1}) ? (y2 - {1'b0, y1}) : '0;
    sup  = {inter_q, 16'b0} > {1'b0, thrp_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.nms_lda) a_q <= box_rd_q;
    if (cmd_i.nms_s1) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      bw_q <= bw;
      bh_q <= bh;
    end
    if (cmd_i.nms_s2) begin
      inter_q <= dx_q * dy_q;
      aa_q    <= aw * ah;
      ab_q    <= bw_q * bh_q;
    end
    // intersection never exceeds either area, so the union cannot wrap
    if (cmd_i.nms_s3) uni_q <= {1'b0, aa_q} + {1'b0, ab_q} - inter_q[2*CoordW:0];
    if (cmd_i.nms_s4) thrp_q <= (2*CoordW+17)'(ovl_thr_q) * (2*CoordW+17)'(uni_q);
  end

  // kept boxes beyond position i, below the box count, decide the last flag
  logic [MaxDets-1:0] rem;
  logic last_c;
  always_comb begin
    for (int p = 0; p < MaxDets; p++) begin
      rem[p] = keep_q[p] && (CntW'(p) > i_q) && (CntW'(p) < cnt_q);
    end
    last_c = ~|rem;
  end

  // control counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      fe_q      <= 1'b0;
      emitted_q <= 1'b0;
      keep_q    <= '1;
      k_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      rank_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        fe_q <= in_i.frame_end;
        k_q  <= '0;
        if (conf_ok && full) ovf_q <= 1'b1;
      end
      if (cmd_i.dec_step) k_q <= k_q + 3'd1;
      if (cmd_i.store) cnt_q <= cnt_q + CntW'(1);
      if (cmd_i.clr_i) begin
        i_q <= '0;
      end else if (cmd_i.i_inc || cmd_i.srt_wr) begin
        i_q <= i_q + CntW'(1);
      end
      if (cmd_i.srt_ldi) begin
        j_q    <= '0;
        rank_q <= '0;
      end
      if (cmd_i.srt_cmp) begin
        j_q <= j_q + CntW'(1);
        if (ahead) rank_q <= rank_q + IdxW'(1);
      end
      if (cmd_i.nms_lda) j_q <= i_q + CntW'(1);
      if (cmd_i.nms_s5) begin
        j_q <= j_q + CntW'(1);
        if (sup) keep_q[j_q[IdxW-1:0]] <= 1'b0;
      end
      if (cmd_i.out_load) emitted_q <= 1'b1;
      if (cmd_i.finish) begin
        cnt_q     <= '0;
        ovf_q     <= 1'b0;
        emitted_q <= 1'b0;
        keep_q    <= '1;
      end
    end
  end

  // output register
  logic out_valid_q;
  dd_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load || cmd_i.nobox_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.left       <= box_rd_q[0 +: CoordW];
      out_q.top        <= box_rd_q[CoordW +: CoordW];
      out_q.width      <= box_rd_q[2*CoordW +: CoordW];
      out_q.height     <= box_rd_q[3*CoordW +: CoordW];
      out_q.label      <= sc_rd_q[ScoreW +: ClassW];
      out_q.confidence <= sc_rd_q[ScoreW-1:0];
      out_q.last_box   <= last_c;
      out_q.no_box     <= 1'b0;
      out_q.overflow   <= ovf_q;
    end else if (cmd_i.nobox_load) begin
      out_q.left       <= '0;
      out_q.top        <= '0;
      out_q.width      <= '0;
      out_q.height     <= '0;
      out_q.label      <= '0;
      out_q.confidence <= '0;
      out_q.last_box   <= 1'b1;
      out_q.no_box     <= 1'b1;
      out_q.overflow   <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    sts_o              = '0;
    sts_o.store_ok     = conf_ok && !full;
    sts_o.in_frame_end = in_i.frame_end;
    sts_o.frame_end    = fe_q;
    sts_o.dec_last     = (k_q == 3'(NumCorners));
    sts_o.i_end        = (i_q == cnt_q);
    sts_o.j_end        = (j_q == cnt_q);
    sts_o.j_last       = ((j_q + CntW'(1)) == cnt_q);
    sts_o.keep_i       = keep_q[i_q[IdxW-1:0]];
    sts_o.emitted      = emitted_q;
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> cnt_q < CntW'(MaxDets))
    else $error("store issued with full box storage");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (cnt_q == '0) && (&keep_q) && !ovf_q)
    else $error("frame state not restored after frame end");

  a_nobox_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.no_box) |-> (out_q.last_box && out_q.left == '0 &&
      out_q.top == '0 && out_q.width == '0 && out_q.height == '0 &&
      out_q.confidence == '0 && out_q.label == '0))
    else $error("empty-frame result carries box fields");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load || cmd_i.nobox_load) |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while a result waits");

endmodule
